/* src/tpcp_pkg.sv */
// Package with the shared widths, constants and control types of the three-phase PWM core.
package tpcp_pkg;

    localparam int FRAC_BITS = 15;
    localparam int VDC_BITS  = 16;

    localparam int DUTY_W = 17;
    localparam int STEP_W = 16;
    localparam int CAR_W  = FRAC_BITS + 1;
    localparam int VOLT_W = VDC_BITS + 1;

    localparam int SUM_W  = ((CAR_W > STEP_W) ? CAR_W : STEP_W) + 2;
    localparam int DCMP_W = ((CAR_W > DUTY_W) ? CAR_W : DUTY_W) + 1;

    localparam logic [CAR_W-1:0]  FULL_SCALE = CAR_W'(64'd1 << FRAC_BITS);
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(64);

    localparam int PROD_W = 2 * VDC_BITS + 2;
    localparam logic [VDC_BITS:0] RECIP_3 =
        (VDC_BITS + 1)'(((64'd1 << (VDC_BITS + 1)) + 64'd2) / 64'd3);

    localparam int NUM_PH = 3;

    localparam int IN_FIELDS_W  = NUM_PH * DUTY_W + VDC_BITS;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = NUM_PH * VOLT_W + 2 * NUM_PH + CAR_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic en;
        logic latch;
    } t_lane_ctl;

    typedef struct packed {
        logic                valid;
        logic [CAR_W-1:0]    carrier;
        logic                crest;
        logic [VDC_BITS-1:0] vdc;
    } t_stage1;

    typedef struct packed {
        logic [VOLT_W-1:0] volt_u;
        logic [VOLT_W-1:0] volt_v;
        logic [VOLT_W-1:0] volt_w;
        logic [NUM_PH-1:0] top;
        logic [CAR_W-1:0]  carrier;
        logic              crest;
    } t_result;

endpackage

/* src/tpcp_carrier.sv */
// Triangular carrier generator with the step register and the first pipeline stage.
module tpcp_carrier
    import tpcp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [STEP_W-1:0]   i_cfg_data,
    input  logic                i_accept,
    input  logic                i_en,
    input  logic [VDC_BITS-1:0] i_vdc,
    output logic                o_crest_now,
    output t_stage1             o_stage1
);

    logic [STEP_W-1:0]   r_step;
    logic [CAR_W-1:0]    r_level;
    logic                r_down;
    logic                r_v1;
    logic [CAR_W-1:0]    r_c1;
    logic                r_crest1;
    logic [VDC_BITS-1:0] r_vdc1;

    logic [SUM_W-1:0] sum_up;
    logic [SUM_W-1:0] sum_dn;
    logic [SUM_W-1:0] raw;
    logic             crest;
    logic             trough;
    logic [CAR_W-1:0] n_level;
    logic             n_down;

    always_comb begin
        sum_up = SUM_W'(r_level) + SUM_W'(r_step);
        sum_dn = SUM_W'(r_level) - SUM_W'(r_step);
        raw    = r_down ? sum_dn : sum_up;
        crest  = $signed(raw) >= $signed(SUM_W'(FULL_SCALE));
        trough = $signed(raw) <= $signed(SUM_W'(0));
        if (crest) begin
            n_level = FULL_SCALE;
            n_down  = 1'b1;
        end else if (trough) begin
            n_level = '0;
            n_down  = 1'b0;
        end else begin
            n_level = raw[CAR_W-1:0];
            n_down  = r_down;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= STEP_RESET;
            r_level <= '0;
            r_down  <= 1'b0;
            r_v1    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_step <= i_cfg_data;
            end
            if (i_accept) begin
                r_level <= n_level;
                r_down  <= n_down;
            end
            if (i_en) begin
                r_v1 <= i_accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1     <= n_level;
            r_crest1 <= crest;
            r_vdc1   <= i_vdc;
        end
    end

    assign o_crest_now      = crest;
    assign o_stage1.valid   = r_v1;
    assign o_stage1.carrier = r_c1;
    assign o_stage1.crest   = r_crest1;
    assign o_stage1.vdc     = r_vdc1;

endmodule

/* src/tpcp_lane.sv */
// One phase lane: duty saturation and latch, and the carrier compare that sets the top switch.
module tpcp_lane
    import tpcp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_lane_ctl         i_ctl,
    input  logic [DUTY_W-1:0] i_duty,
    input  logic [CAR_W-1:0]  i_carrier,
    output logic              o_gate
);

    logic [CAR_W-1:0]  r_latched;
    logic              r_gate;
    logic [DCMP_W-1:0] duty_ext;
    logic [CAR_W-1:0]  n_latched;

    always_comb begin
        duty_ext = DCMP_W'($signed(i_duty));
        if ($signed(duty_ext) >= $signed(DCMP_W'(FULL_SCALE))) begin
            n_latched = FULL_SCALE;
        end else if ($signed(duty_ext) <= $signed(DCMP_W'(0))) begin
            n_latched = '0;
        end else begin
            n_latched = duty_ext[CAR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched <= '0;
        end else if (i_ctl.latch) begin
            r_latched <= n_latched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_gate <= (r_latched >= i_carrier);
        end
    end

    assign o_gate = r_gate;

endmodule

/* src/tpcp_merge.sv */
// Merging stage: combines the lane gates into phase-to-neutral voltages and the result register.
module tpcp_merge
    import tpcp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_stage1           i_stage1,
    input  logic [NUM_PH-1:0] i_gates,
    output logic              o_valid,
    output t_result           o_result
);

    logic                r_v2;
    logic [PROD_W-1:0]   r_prod;
    logic [VDC_BITS-1:0] r_vdc2;
    logic [CAR_W-1:0]    r_c2;
    logic                r_crest2;
    logic                r_v3;
    t_result             r_res;

    logic [VDC_BITS-1:0] third;
    logic [VDC_BITS+1:0] rem;
    logic [VDC_BITS:0]   two_third;
    logic [1:0]          sum;
    logic [VOLT_W-1:0]   volt [NUM_PH];
    logic [VDC_BITS-1:0] mag;
    logic                neg;

    always_comb begin
        third     = r_prod[VDC_BITS+1 +: VDC_BITS];
        rem       = (VDC_BITS + 2)'(r_vdc2) - (VDC_BITS + 2)'({third, 1'b0})
                    - (VDC_BITS + 2)'(third);
        two_third = {third, 1'b0} + (VDC_BITS + 1)'(rem >= (VDC_BITS + 2)'(2));
        sum       = 2'(i_gates[0]) + 2'(i_gates[1]) + 2'(i_gates[2]);
        for (int k = 0; k < NUM_PH; k++) begin
            mag = '0;
            neg = 1'b0;
            if (i_gates[k]) begin
                case (sum)
                    2'd1:    mag = two_third[VDC_BITS-1:0];
                    2'd2:    mag = third;
                    default: mag = '0;
                endcase
            end else begin
                neg = 1'b1;
                case (sum)
                    2'd1:    mag = third;
                    2'd2:    mag = two_third[VDC_BITS-1:0];
                    default: mag = '0;
                endcase
            end
            volt[k] = neg ? (VOLT_W'(0) - VOLT_W'(mag)) : VOLT_W'(mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= i_stage1.valid;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod          <= PROD_W'(i_stage1.vdc) * PROD_W'(RECIP_3);
            r_vdc2          <= i_stage1.vdc;
            r_c2            <= i_stage1.carrier;
            r_crest2        <= i_stage1.crest;
            r_res.volt_u    <= volt[0];
            r_res.volt_v    <= volt[1];
            r_res.volt_w    <= volt[2];
            r_res.top       <= i_gates;
            r_res.carrier   <= r_c2;
            r_res.crest     <= r_crest2;
        end
    end

    assign o_valid  = r_v3;
    assign o_result = r_res;

endmodule

/* src/three_phase_center_aligned_pwm_core.sv */
// Top level of the center-aligned three-phase PWM core with ideal bridge voltages.
//
// Each input transaction is one tick: the triangular carrier steps by the
// configured amount, duties are latched at the crest, and one result
// transaction follows with gate states, the carrier and the phase voltages.
// A new tick is accepted every clock cycle unless the output stalls; the
// stages are the carrier stage, the lane compare with the divide-by-three
// multiply, and the voltage merge into the output register. The carrier
// step register is written through the configuration channel, which is
// always ready, and should only be written while no tick is in flight.
module three_phase_center_aligned_pwm_core
    import tpcp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [STEP_W-1:0]      i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // duty_u, duty_v, duty_w, dc_link_voltage, zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // volt_u_neutral, volt_v_neutral, volt_w_neutral, top_gates,
    // bottom_gates, carrier_now, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // crest_latched
    output logic                   m_axis_tuser
);

    logic                en;
    logic                accept;
    logic                crest_now;
    t_stage1             stage1;
    t_lane_ctl           lane_ctl;
    logic [NUM_PH-1:0]   gates;
    logic                res_valid;
    t_result             res;
    logic [DUTY_W-1:0]   duty [NUM_PH];
    logic [VDC_BITS-1:0] vdc;

    assign en     = !res_valid || m_axis_tready;
    assign accept = s_axis_tvalid && en;

    assign s_axis_tready = en;
    assign o_cfg_ready   = 1'b1;

    assign duty[0] = s_axis_tdata[0 +: DUTY_W];
    assign duty[1] = s_axis_tdata[DUTY_W +: DUTY_W];
    assign duty[2] = s_axis_tdata[2 * DUTY_W +: DUTY_W];
    assign vdc     = s_axis_tdata[NUM_PH * DUTY_W +: VDC_BITS];

    tpcp_carrier u_carrier (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_en        (en),
        .i_vdc       (vdc),
        .o_crest_now (crest_now),
        .o_stage1    (stage1)
    );

    assign lane_ctl.en    = en;
    assign lane_ctl.latch = accept && crest_now;

    for (genvar g = 0; g < NUM_PH; g++) begin : g_lane
        tpcp_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (lane_ctl),
            .i_duty    (duty[g]),
            .i_carrier (stage1.carrier),
            .o_gate    (gates[g])
        );
    end

    tpcp_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_stage1 (stage1),
        .i_gates  (gates),
        .o_valid  (res_valid),
        .o_result (res)
    );

    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({res.carrier, ~res.top, res.top,
                                         res.volt_w, res.volt_v, res.volt_u});
    assign m_axis_tuser  = res.crest;

endmodule
